// ===== rtl/lpmd_pkg.sv =====
package lpmd_pkg;

  localparam int unsigned IdW    = 14;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 24;

  typedef enum logic [1:0] {
    PH_HDR_HI  = 2'd0,
    PH_HDR_LO  = 2'd1,
    PH_LEN     = 2'd2,
    PH_PAYLOAD = 2'd3
  } lpmd_phase_t;

  typedef struct packed {
    logic [IdW-1:0]   msg_id;
    logic [ByteW-1:0] payload_byte;
    logic             data_valid;
    logic             last;
  } lpmd_rec_t;

  typedef struct packed {
    logic      wr_en;
    lpmd_rec_t rec;
  } lpmd_wr_t;

endpackage

// ===== rtl/lpmd_parse.sv =====
module lpmd_parse
  import lpmd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [ByteW-1:0] rx_byte,
  output lpmd_wr_t         wr
);

  lpmd_phase_t       phase_r, phase_nxt;
  logic [ByteW-1:0]  header_high_r, header_high_nxt;
  logic [IdW-1:0]    id_r, id_nxt;
  logic [1:0]        len_left_r, len_left_nxt;
  logic [CountW-1:0] remaining_r, remaining_nxt;
  logic [CountW-1:0] len_acc;
  logic [CountW-1:0] rem_dec;

  assign len_acc = {remaining_r[CountW-ByteW-1:0], rx_byte};
  assign rem_dec = remaining_r - CountW'(1);

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HDR_HI: begin
        phase_nxt = PH_HDR_LO;
      end
      PH_HDR_LO: begin
        phase_nxt = (rx_byte[1:0] == 2'd0) ? PH_HDR_HI : PH_LEN;
      end
      PH_LEN: begin
        if (len_left_r == 2'd1) begin
          phase_nxt = (len_acc == '0) ? PH_HDR_HI : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (rem_dec == '0) begin
          phase_nxt = PH_HDR_HI;
        end
      end
      default: begin
        phase_nxt = PH_HDR_HI;
      end
    endcase
  end

  always_comb begin
    header_high_nxt       = header_high_r;
    id_nxt                = id_r;
    len_left_nxt          = len_left_r;
    remaining_nxt         = remaining_r;
    wr.wr_en              = 1'b0;
    wr.rec.payload_byte   = '0;
    wr.rec.data_valid     = 1'b0;
    wr.rec.last           = 1'b1;
    unique case (phase_r)
      PH_HDR_HI: begin
        header_high_nxt = rx_byte;
      end
      PH_HDR_LO: begin
        id_nxt        = {header_high_r, rx_byte[ByteW-1:2]};
        len_left_nxt  = rx_byte[1:0];
        remaining_nxt = '0;
        wr.wr_en      = take && (rx_byte[1:0] == 2'd0);
      end
      PH_LEN: begin
        remaining_nxt = len_acc;
        len_left_nxt  = len_left_r - 2'd1;
        wr.wr_en      = take && (len_left_r == 2'd1) && (len_acc == '0);
      end
      PH_PAYLOAD: begin
        remaining_nxt       = rem_dec;
        wr.wr_en            = take;
        wr.rec.payload_byte = rx_byte;
        wr.rec.data_valid   = 1'b1;
        wr.rec.last         = (rem_dec == '0);
      end
      default: begin
        header_high_nxt = rx_byte;
      end
    endcase
    wr.rec.msg_id = id_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HDR_HI;
      header_high_r <= '0;
      id_r          <= '0;
      len_left_r    <= '0;
      remaining_r   <= '0;
    end else if (take) begin
      phase_r       <= phase_nxt;
      header_high_r <= header_high_nxt;
      id_r          <= id_nxt;
      len_left_r    <= len_left_nxt;
      remaining_r   <= remaining_nxt;
    end
  end

endmodule

// ===== rtl/lpmd_queue.sv =====
module lpmd_queue
  import lpmd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
)(
  input  logic      clk,
  input  logic      rst_n,
  input  lpmd_wr_t  wr,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output lpmd_rec_t head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  lpmd_rec_t       mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_wr, do_rd;

  assign full  = (count_r == CntW'(DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = wr.wr_en && !full;
  assign do_rd = pop && !empty;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/length_prefixed_message_deframer.sv =====
// Deframes a byte stream of length-prefixed messages, one byte per request.
// Input side: a byte on in_rx_byte is taken at a clock edge where push is high
// and full is low. Each message is a big-endian 16-bit header (14-bit id, 2-bit
// length-field size), a big-endian length of 0 to 3 bytes, then the payload.
// Result side: while empty is low the oldest result is on the out_ ports, and
// it is taken at an edge where pop is high. Each payload byte gives one result
// tagged with its message id and a last flag; an empty message gives a single
// result with data_valid low and last high; header and length bytes give no other.
// A result is written into the queue at the edge that takes its byte, and one
// byte can be taken in every cycle in which full is low.
// Results wait in a DEPTH-entry queue; if the receiver stalls, full rises once
// the queue holds DEPTH results and input is held off until pop frees a place.
// Reset empties the queue and returns the parser to waiting for a header.
module length_prefixed_message_deframer
  import lpmd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
)(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [ByteW-1:0] in_rx_byte,
  output logic             empty,
  input  logic             pop,
  output logic [IdW-1:0]   out_msg_id,
  output logic [ByteW-1:0] out_payload_byte,
  output logic             out_data_valid,
  output logic             out_last
);

  logic      take;
  lpmd_wr_t  wr;
  lpmd_rec_t head;

  assign take = push && !full;

  lpmd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .wr      (wr)
  );

  lpmd_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .pop   (pop),
    .full  (full),
    .empty (empty),
    .head  (head)
  );

  assign out_msg_id       = head.msg_id;
  assign out_payload_byte = head.payload_byte;
  assign out_data_valid   = head.data_valid;
  assign out_last         = head.last;

  a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(full && empty))
    else $error("queue reports full and empty together");

  a_wr_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.wr_en && empty) |=> !empty)
    else $error("result written into an empty queue was lost");

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.wr_en && !wr.rec.data_valid) |-> wr.rec.last)
    else $error("empty-message marker without last");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |=> full)
    else $error("full queue drained without a pop");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lpmd_pkg::*;

  class deframer_scoreboard;
    lpmd_phase_t        phase;
    logic [ByteW-1:0]   hdr_hi;
    logic [IdW-1:0]     cur_id;
    logic [1:0]         len_left;
    logic [CountW-1:0]  remaining;
    lpmd_rec_t          due_results[$];
    int                 errors;
    int                 bytes_taken;
    int                 results_seen;
    int                 empties_seen;

    function new();
      phase        = PH_HDR_HI;
      hdr_hi       = '0;
      cur_id       = '0;
      len_left     = '0;
      remaining    = '0;
      errors       = 0;
      bytes_taken  = 0;
      results_seen = 0;
      empties_seen = 0;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void queue_result(logic [ByteW-1:0] b, logic dv, logic lst);
      lpmd_rec_t r;
      r.msg_id       = cur_id;
      r.payload_byte = b;
      r.data_valid   = dv;
      r.last         = lst;
      due_results.push_back(r);
    endfunction

    // Advances the parser by one accepted byte and queues any result it causes.
    function void note_byte(logic [ByteW-1:0] b);
      logic [15:0] header;
      bytes_taken++;
      case (phase)
        PH_HDR_LO: begin
          header    = {hdr_hi, b};
          cur_id    = header[15:2];
          remaining = '0;
          if (header[1:0] == 2'd0) begin
            len_left = 2'd0;
            phase    = PH_HDR_HI;
            queue_result('0, 1'b0, 1'b1);
          end else begin
            len_left = header[1:0];
            phase    = PH_LEN;
          end
        end
        PH_LEN: begin
          remaining = {remaining[CountW-9:0], b};
          len_left  = len_left - 2'd1;
          if (len_left == 2'd0) begin
            if (remaining == '0) begin
              phase = PH_HDR_HI;
              queue_result('0, 1'b0, 1'b1);
            end else begin
              phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          remaining = remaining - CountW'(1);
          queue_result(b, 1'b1, remaining == '0);
          if (remaining == '0) phase = PH_HDR_HI;
        end
        default: begin
          hdr_hi = b;
          phase  = PH_HDR_LO;
        end
      endcase
    endfunction

    task check_result(lpmd_rec_t got);
      lpmd_rec_t want;
      results_seen++;
      if (!got.data_valid) empties_seen++;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, id %0h", got.msg_id));
      end else begin
        want = due_results.pop_front();
        if (got.msg_id !== want.msg_id)
          report_mismatch($sformatf("msg_id %0h, expected %0h", got.msg_id, want.msg_id));
        if (got.payload_byte !== want.payload_byte)
          report_mismatch($sformatf("payload_byte %0h, expected %0h",
                                    got.payload_byte, want.payload_byte));
        if (got.data_valid !== want.data_valid)
          report_mismatch($sformatf("data_valid %0b, expected %0b",
                                    got.data_valid, want.data_valid));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             push;
  logic             full;
  logic [ByteW-1:0] in_rx_byte;
  logic             empty;
  logic             pop;
  logic [IdW-1:0]   out_msg_id;
  logic [ByteW-1:0] out_payload_byte;
  logic             out_data_valid;
  logic             out_last;

  deframer_scoreboard sb;
  bit                 calm;
  bit                 stream_done;
  int                 messages_sent;

  length_prefixed_message_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_rx_byte       (in_rx_byte),
    .empty            (empty),
    .pop              (pop),
    .out_msg_id       (out_msg_id),
    .out_payload_byte (out_payload_byte),
    .out_data_valid   (out_data_valid),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", sb.due_results.size());
    $display("Some tests failed");
    $finish;
  end

  task send_byte(logic [ByteW-1:0] b);
    if (!calm && $urandom_range(99) < 28) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push       <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (full);
    sb.note_byte(b);
    calm = (sb.bytes_taken >= 500 && sb.bytes_taken < 700);
  endtask

  task send_message(logic [IdW-1:0] id, logic [1:0] lsize, int unsigned len);
    logic [15:0] header;
    logic [23:0] len_field;
    header    = {id, lsize};
    len_field = 24'(len);
    send_byte(header[15:8]);
    send_byte(header[7:0]);
    for (int i = int'(lsize); i > 0; i--) send_byte(len_field[8*i-1 -: 8]);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
    messages_sent++;
  endtask

  initial begin
    logic [ByteW-1:0] directed [24];
    logic [1:0]  lsize;
    int unsigned len;
    int unsigned pick;
    directed = '{
      8'hFF, 8'hFC,
      8'h00, 8'h01, 8'h00,
      8'h12, 8'h36, 8'h00, 8'h00,
      8'hAB, 8'hCF, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h09, 8'h01, 8'hFF,
      8'h00, 8'h0E, 8'h00, 8'h02, 8'h00, 8'hAA
    };
    sb            = new();
    calm          = 1'b0;
    stream_done   = 1'b0;
    messages_sent = 6;
    rst_n         <= 1'b0;
    push          <= 1'b0;
    in_rx_byte    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_byte(directed[i]);

    while (sb.bytes_taken < 1124) begin
      lsize = 2'($urandom_range(3));
      pick  = $urandom_range(99);
      if (lsize == 2'd0 || pick < 10)
        len = 0;
      else if (pick < 85)
        len = $urandom_range(1, 8);
      else if (pick < 97)
        len = $urandom_range(9, 40);
      else if (lsize == 2'd1)
        len = $urandom_range(200, 255);
      else
        len = $urandom_range(256, 300);
      send_message(14'($urandom_range(16383)), lsize, len);
    end
    push <= 1'b0;
    stream_done = 1'b1;

    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Fed %0d bytes in %0d messages; checked %0d results, %0d of them empty markers.",
             sb.bytes_taken, messages_sent, sb.results_seen, sb.empties_seen);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches found.", sb.errors);
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    lpmd_rec_t got;
    bit        held;
    held = 1'b0;
    pop  <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && sb.results_seen >= 300) begin
        held = 1'b1;
        pop <= 1'b0;
        for (int i = 0; i < 200; i++) @(posedge clk);
      end
      pop <= calm || ($urandom_range(99) >= 28);
      @(posedge clk);
      if (pop && !empty) begin
        got.msg_id       = out_msg_id;
        got.payload_byte = out_payload_byte;
        got.data_valid   = out_data_valid;
        got.last         = out_last;
        sb.check_result(got);
      end
    end
  end

endmodule
